@@ hdl/grid_dda_ray_cell_walk_core_macros.svh @@
// Assertion helpers for the grid ray walk core.
// All checks are clocked on clk_i and disabled while rst_ni is low.
`ifndef GRID_DDA_RAY_CELL_WALK_CORE_MACROS_SVH
`define GRID_DDA_RAY_CELL_WALK_CORE_MACROS_SVH

// Condition must hold at every edge.
`define GDW_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// When trig holds, cond must hold at the next edge.
`define GDW_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (trig) |=> (cond)) else $error(msg);

`endif

@@ hdl/gdw_pkg.sv @@
// ----------------------------------------------------------------------------
// gdw_pkg
// Shared types and constants of the grid ray walk core.
// ----------------------------------------------------------------------------
package gdw_pkg;

  localparam int GridRowsDef = 32;
  localparam int GridColsDef = 32;
  localparam int MaxOut      = 63;

  // configuration register indexes
  localparam logic [2:0] CfgCellWidth = 3'd0;
  localparam logic [2:0] CfgCellDepth = 3'd1;
  localparam logic [2:0] CfgOriginX   = 3'd2;
  localparam logic [2:0] CfgOriginZ   = 3'd3;

  // classified ray handed from front to back
  typedef struct packed {
    logic        miss;
    logic [4:0]  row;
    logic [4:0]  col;
    logic [30:0] dist_x;
    logic [30:0] dist_z;
    logic [15:0] adx;
    logic [15:0] adz;
    logic        neg_x;
    logic        neg_z;
    logic [4:0]  min_c;
    logic [4:0]  min_r;
    logic [4:0]  max_c;
    logic [4:0]  max_r;
  } job_t;

  // one result item
  typedef struct packed {
    logic [4:0] row;
    logic [4:0] col;
    logic       valid;
    logic       last;
  } res_t;

endpackage

@@ hdl/grid_dda_ray_cell_walk_core.sv @@
// ----------------------------------------------------------------------------
// grid_dda_ray_cell_walk_core
// 2D uniform-grid ray walk: emits the cells a ray crosses inside a window, at most 63 per ray.
// ----------------------------------------------------------------------------
// channel | direction | handshake                 | payload
// ray     | in        | push / full               | origin, direction, window
// cell    | out       | pop / empty               | row, col, valid, last
// config  | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// The front takes one ray at a time: it accepts the ray, runs the two
// bit-serial dividers (32 steps and a done check), then hands the job off.
// The back pops a job, forms four products on a shared multiplier, then
// emits one cell per cycle while the result queue has room.
// Reset clears all control state and loads cell sizes 1.0 and origin 0.
// A full result queue stalls the walk; a full job queue stalls the front.
// ----------------------------------------------------------------------------
module grid_dda_ray_cell_walk_core #(
  parameter int GRID_ROWS = gdw_pkg::GridRowsDef,
  parameter int GRID_COLS = gdw_pkg::GridColsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] ray_origin_x_i,
  input  logic signed [31:0] ray_origin_z_i,
  input  logic signed [15:0] ray_dir_x_i,
  input  logic signed [15:0] ray_dir_z_i,
  input  logic [4:0]         min_col_i,
  input  logic [4:0]         min_row_i,
  input  logic [4:0]         max_col_i,
  input  logic [4:0]         max_row_i,
  output logic               empty,
  input  logic               pop,
  output logic [4:0]         cell_row_o,
  output logic [4:0]         cell_col_o,
  output logic               cell_valid_o,
  output logic               last_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import gdw_pkg::*;

  logic [30:0]        cw_q, cd_q, cs_x, cs_z;
  logic signed [31:0] gox_q, goz_q;
  logic               cfg_we;

  job_t job_in, job_out;
  logic job_push, job_full, job_pop, job_empty;
  res_t res_in, res_out;
  logic res_push, res_full;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_q  <= 31'd65536;
      cd_q  <= 31'd65536;
      gox_q <= '0;
      goz_q <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        CfgCellWidth: cw_q  <= cfg_data_i[30:0];
        CfgCellDepth: cd_q  <= cfg_data_i[30:0];
        CfgOriginX:   gox_q <= cfg_data_i;
        CfgOriginZ:   goz_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // a zero cell size acts as one raw unit
  assign cs_x = (cw_q == '0) ? 31'd1 : cw_q;
  assign cs_z = (cd_q == '0) ? 31'd1 : cd_q;

  gdw_front #(.GridRows(GRID_ROWS), .GridCols(GRID_COLS)) u_front (
    .clk_i, .rst_ni,
    .push_i(push), .full_o(full),
    .ray_origin_x_i, .ray_origin_z_i, .ray_dir_x_i, .ray_dir_z_i,
    .min_col_i, .min_row_i, .max_col_i, .max_row_i,
    .cs_x_i(cs_x), .cs_z_i(cs_z), .org_x_i(gox_q), .org_z_i(goz_q),
    .job_push_o(job_push), .job_o(job_in), .job_full_i(job_full)
  );

  gdw_fifo #(.Width($bits(job_t)), .Depth(2)) u_job_q (
    .clk_i, .rst_ni,
    .push_i(job_push), .data_i(job_in), .full_o(job_full),
    .pop_i(job_pop), .data_o(job_out), .empty_o(job_empty)
  );

  gdw_back u_back (
    .clk_i, .rst_ni, .cs_x_i(cs_x), .cs_z_i(cs_z),
    .job_empty_i(job_empty), .job_i(job_out), .job_pop_o(job_pop),
    .res_push_o(res_push), .res_o(res_in), .res_full_i(res_full)
  );

  gdw_fifo #(.Width($bits(res_t)), .Depth(2)) u_res_q (
    .clk_i, .rst_ni,
    .push_i(res_push), .data_i(res_in), .full_o(res_full),
    .pop_i(pop), .data_o(res_out), .empty_o(empty)
  );

  assign cell_row_o   = res_out.row;
  assign cell_col_o   = res_out.col;
  assign cell_valid_o = res_out.valid;
  assign last_o       = res_out.last;
endmodule

@@ hdl/gdw_fifo.sv @@
// ----------------------------------------------------------------------------
// gdw_fifo
// Small register queue, head shown while not empty.
// ----------------------------------------------------------------------------
module gdw_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end
endmodule

@@ hdl/gdw_div.sv @@
// ----------------------------------------------------------------------------
// gdw_div
// Restoring divider, 32-bit dividend by 31-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module gdw_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [30:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o,
  output logic [30:0] rem_o
);
  logic        busy_q;
  logic [4:0]  cnt_q;
  logic [30:0] acc_q, acc_d;
  logic [31:0] qd_q, qd_d;
  logic [31:0] trial;
  logic        ge;

  // one shift-subtract step
  always_comb begin
    trial = {acc_q, qd_q[31]};
    ge    = (trial >= {1'b0, divisor_i});
    acc_d = ge ? 31'(trial - {1'b0, divisor_i}) : trial[30:0];
    qd_d  = {qd_q[30:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 5'd31;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      qd_q  <= dividend_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      qd_q  <= qd_d;
    end
  end

  assign done_o = !busy_q;
  assign quot_o = qd_q;
  assign rem_o  = acc_q;
endmodule

@@ hdl/gdw_front.sv @@
// ----------------------------------------------------------------------------
// gdw_front
// Takes a ray, finds its start cell and boundary distances, classifies it.
// ----------------------------------------------------------------------------
module gdw_front #(
  parameter int GridRows = 32,
  parameter int GridCols = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic signed [31:0] ray_origin_x_i,
  input  logic signed [31:0] ray_origin_z_i,
  input  logic signed [15:0] ray_dir_x_i,
  input  logic signed [15:0] ray_dir_z_i,
  input  logic [4:0]         min_col_i,
  input  logic [4:0]         min_row_i,
  input  logic [4:0]         max_col_i,
  input  logic [4:0]         max_row_i,
  input  logic [30:0]        cs_x_i,
  input  logic [30:0]        cs_z_i,
  input  logic signed [31:0] org_x_i,
  input  logic signed [31:0] org_z_i,
  output logic               job_push_o,
  output gdw_pkg::job_t      job_o,
  input  logic               job_full_i
);
  import gdw_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StPush = 2'd2;

  localparam logic [4:0] ColTop = 5'(GridCols - 1);
  localparam logic [4:0] RowTop = 5'(GridRows - 1);

  logic [1:0] st_q, st_d;
  logic       accept;

  logic signed [32:0] ox, oz;
  logic [31:0]        abs_x, abs_z;
  logic               sox_q, soz_q;
  logic [15:0]        dx_q, dz_q;
  logic [4:0]         min_c_q, min_r_q, max_c_q, max_r_q;

  logic        dvx_done, dvz_done;
  logic [31:0] qx, qz;
  logic [30:0] rx, rz;

  logic signed [32:0] col_s, row_s;
  logic [30:0]        rpx, rpz;
  logic               in_win;

  assign accept = push_i && !full_o;
  assign full_o = (st_q != StIdle);

  // offsets from grid origin, magnitudes for the dividers
  always_comb begin
    ox    = 33'(ray_origin_x_i) - 33'(org_x_i);
    oz    = 33'(ray_origin_z_i) - 33'(org_z_i);
    abs_x = ox[32] ? 32'(-ox) : ox[31:0];
    abs_z = oz[32] ? 32'(-oz) : oz[31:0];
  end

  gdw_div u_div_x (
    .clk_i, .rst_ni, .start_i(accept), .dividend_i(abs_x), .divisor_i(cs_x_i),
    .done_o(dvx_done), .quot_o(qx), .rem_o(rx)
  );
  gdw_div u_div_z (
    .clk_i, .rst_ni, .start_i(accept), .dividend_i(abs_z), .divisor_i(cs_z_i),
    .done_o(dvz_done), .quot_o(qz), .rem_o(rz)
  );

  // ray fields held for the classify step
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sox_q   <= ox[32];
      soz_q   <= oz[32];
      dx_q    <= ray_dir_x_i;
      dz_q    <= ray_dir_z_i;
      min_c_q <= min_col_i;
      min_r_q <= min_row_i;
      max_c_q <= (max_col_i > ColTop) ? ColTop : max_col_i;
      max_r_q <= (max_row_i > RowTop) ? RowTop : max_row_i;
    end
  end

  // signed start cell, boundary distance along travel, window check
  always_comb begin
    col_s  = sox_q ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    row_s  = soz_q ? -$signed({1'b0, qz}) : $signed({1'b0, qz});
    rpx    = (sox_q && rx != '0) ? 31'(cs_x_i - rx) : rx;
    rpz    = (soz_q && rz != '0) ? 31'(cs_z_i - rz) : rz;
    in_win = (col_s >= $signed({28'd0, min_c_q})) && (col_s <= $signed({28'd0, max_c_q}))
          && (row_s >= $signed({28'd0, min_r_q})) && (row_s <= $signed({28'd0, max_r_q}));
    job_o        = '0;
    job_o.miss   = !in_win;
    job_o.col    = col_s[4:0];
    job_o.row    = row_s[4:0];
    job_o.dist_x = dx_q[15] ? rpx : 31'(cs_x_i - rpx);
    job_o.dist_z = dz_q[15] ? rpz : 31'(cs_z_i - rpz);
    job_o.adx    = dx_q[15] ? 16'(-dx_q) : dx_q;
    job_o.adz    = dz_q[15] ? 16'(-dz_q) : dz_q;
    job_o.neg_x  = dx_q[15];
    job_o.neg_z  = dz_q[15];
    job_o.min_c  = min_c_q;
    job_o.min_r  = min_r_q;
    job_o.max_c  = max_c_q;
    job_o.max_r  = max_r_q;
  end

  assign job_push_o = (st_q == StPush) && !job_full_i;

  // sequencer
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle:  if (accept) st_d = StDiv;
      StDiv:   if (dvx_done && dvz_done) st_d = StPush;
      StPush:  if (!job_full_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
    end else begin
      st_q <= st_d;
    end
  end
endmodule

@@ hdl/gdw_back.sv @@
// ----------------------------------------------------------------------------
// gdw_back
// Walks the grid for one classified ray, one cell per cycle while not stalled.
// ----------------------------------------------------------------------------
`include "grid_dda_ray_cell_walk_core_macros.svh"
module gdw_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [30:0]   cs_x_i,
  input  logic [30:0]   cs_z_i,
  input  logic          job_empty_i,
  input  gdw_pkg::job_t job_i,
  output logic          job_pop_o,
  output logic          res_push_o,
  output gdw_pkg::res_t res_o,
  input  logic          res_full_i
);
  import gdw_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMiss = 2'd1;
  localparam logic [1:0] StMul  = 2'd2;
  localparam logic [1:0] StWalk = 2'd3;

  logic [1:0]  st_q, st_d;
  logic [1:0]  mstep_q;
  job_t        job_q;
  logic [4:0]  row_q, col_q;
  logic [5:0]  cnt_q;
  logic [52:0] px_q, pz_q, kx_q, kz_q;

  logic [30:0] mul_a;
  logic [15:0] mul_b;
  logic [46:0] prod;

  logic              step_col, leave, last;
  logic signed [6:0] nc, nr;
  logic              in_win;

  assign job_pop_o = (st_q == StIdle) && !job_empty_i;

  // shared multiplier for the scaled crossing terms
  always_comb begin
    unique case (mstep_q)
      2'd0:    begin mul_a = job_q.dist_x; mul_b = job_q.adz; end
      2'd1:    begin mul_a = cs_x_i;       mul_b = job_q.adz; end
      2'd2:    begin mul_a = job_q.dist_z; mul_b = job_q.adx; end
      default: begin mul_a = cs_z_i;       mul_b = job_q.adx; end
    endcase
    prod = 47'(mul_a) * 47'(mul_b);
  end

  // step choice; ties and a zero x direction step the row
  always_comb begin
    step_col = (job_q.adx != '0) && ((job_q.adz == '0) || (px_q < pz_q));
    nc = $signed({2'b00, col_q}) + (job_q.neg_x ? -7'sd1 : 7'sd1);
    nr = $signed({2'b00, row_q}) + (job_q.neg_z ? -7'sd1 : 7'sd1);
    if (step_col) begin
      leave = (nc < $signed({2'b00, job_q.min_c})) || (nc > $signed({2'b00, job_q.max_c}));
    end else begin
      leave = (nr < $signed({2'b00, job_q.min_r})) || (nr > $signed({2'b00, job_q.max_r}));
    end
    last = leave || (cnt_q == 6'(MaxOut - 1));
  end

  // walk position inside the job window
  assign in_win = (col_q >= job_q.min_c) && (col_q <= job_q.max_c)
               && (row_q >= job_q.min_r) && (row_q <= job_q.max_r);

  // result item
  always_comb begin
    res_push_o = 1'b0;
    res_o      = '0;
    if (st_q == StMiss) begin
      res_push_o = !res_full_i;
      res_o.last = 1'b1;
    end else if (st_q == StWalk) begin
      res_push_o  = !res_full_i;
      res_o.row   = row_q;
      res_o.col   = col_q;
      res_o.valid = 1'b1;
      res_o.last  = last;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
      row_q <= job_i.row;
      col_q <= job_i.col;
    end else if (st_q == StMul) begin
      unique case (mstep_q)
        2'd0:    px_q <= 53'(prod);
        2'd1:    kx_q <= 53'(prod);
        2'd2:    pz_q <= 53'(prod);
        default: kz_q <= 53'(prod);
      endcase
    end else if (st_q == StWalk && !res_full_i) begin
      if (step_col) begin
        px_q  <= px_q + kx_q;
        col_q <= nc[4:0];
      end else begin
        pz_q  <= pz_q + kz_q;
        row_q <= nr[4:0];
      end
    end
  end

  // sequencer
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle:  if (!job_empty_i) st_d = job_i.miss ? StMiss : StMul;
      StMiss:  if (!res_full_i) st_d = StIdle;
      StMul:   if (mstep_q == 2'd3) st_d = StWalk;
      StWalk:  if (!res_full_i && last) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      mstep_q <= '0;
      cnt_q   <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == StMul) begin
        mstep_q <= mstep_q + 1'b1;
      end else begin
        mstep_q <= '0;
      end
      if (st_q == StIdle) begin
        cnt_q <= '0;
      end else if (st_q == StWalk && !res_full_i) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  `GDW_ASSERT(a_walk_in_window, (st_q != StWalk) || in_win, "walk left window")
  `GDW_ASSERT(a_cnt_cap, (st_q != StWalk) || (cnt_q < 6'(MaxOut)), "result cap exceeded")
  `GDW_ASSERT_NEXT(a_last_ends, res_push_o && res_o.last, st_q == StIdle, "ray not closed after last")
endmodule

@@ sim/tb_grid_dda_ray_cell_walk_core.sv @@
// ----------------------------------------------------------------------------
// tb_grid_dda_ray_cell_walk_core
// Self-checking bench for the 2D grid ray walk. Rays go in from a queue through
// a clocked driver. A clocked monitor pops the cells that come out and compares
// each one with the walk that a behavioral model predicts. Both sides idle at
// random. The register settings change between phases, only while the block
// is idle.
// ----------------------------------------------------------------------------
module tb_grid_dda_ray_cell_walk_core;
  timeunit 1ns;
  timeprecision 1ps;
  import gdw_pkg::*;

  // one ray as it is driven
  typedef struct {
    logic signed [31:0] org_x;
    logic signed [31:0] org_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_z;
    logic [4:0]         min_c;
    logic [4:0]         min_r;
    logic [4:0]         max_c;
    logic [4:0]         max_r;
  } ray_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic signed [31:0] ray_origin_x_i = '0;
  logic signed [31:0] ray_origin_z_i = '0;
  logic signed [15:0] ray_dir_x_i = '0;
  logic signed [15:0] ray_dir_z_i = '0;
  logic [4:0]         min_col_i = '0;
  logic [4:0]         min_row_i = '0;
  logic [4:0]         max_col_i = '0;
  logic [4:0]         max_row_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [4:0]         cell_row_o;
  logic [4:0]         cell_col_o;
  logic               cell_valid_o;
  logic               last_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;

  // register copies of the model
  logic [30:0] width_q = 31'd65536;
  logic [30:0] depth_q = 31'd65536;
  logic [31:0] gx_q = '0;
  logic [31:0] gz_q = '0;

  ray_t ray_q[$];
  res_t cell_q[$];
  int   err_cnt = 0;
  int   ray_gap = 0;
  int   pop_gap = 0;
  bit   calm = 1'b0;

  grid_dda_ray_cell_walk_core uut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // expected cells of one ray
  function automatic void walk_ray(ray_t r);
    longint cw, cd, ox, oz, dx, dz, col, row, rx, rz, mc, mr, mic, mir;
    longint unsigned adx, adz, tx, tz;
    int n;
    bit step_col;
    res_t c;
    cw = (width_q == 0) ? 1 : longint'(width_q);
    cd = (depth_q == 0) ? 1 : longint'(depth_q);
    ox = longint'(r.org_x) - longint'($signed(gx_q));
    oz = longint'(r.org_z) - longint'($signed(gz_q));
    dx = longint'(r.dir_x);
    dz = longint'(r.dir_z);
    adx = (dx < 0) ? -dx : dx;
    adz = (dz < 0) ? -dz : dz;
    mic = longint'(r.min_c);
    mir = longint'(r.min_r);
    mc = (r.max_c > 31) ? 31 : longint'(r.max_c);
    mr = (r.max_r > 31) ? 31 : longint'(r.max_r);
    // start cell truncates toward zero; distance to the next boundary
    col = ox / cw;
    rx = ox % cw;
    if (rx < 0) rx += cw;
    tx = (dx < 0) ? rx : cw - rx;
    row = oz / cd;
    rz = oz % cd;
    if (rz < 0) rz += cd;
    tz = (dz < 0) ? rz : cd - rz;
    if (row < mir || row > mr || col < mic || col > mc) begin
      c = '{row: 5'd0, col: 5'd0, valid: 1'b0, last: 1'b1};
      cell_q.push_back(c);
      return;
    end
    n = 0;
    forever begin
      c = '{row: row[4:0], col: col[4:0], valid: 1'b1, last: 1'b0};
      n++;
      if (adx == 0) step_col = 1'b0;
      else if (adz == 0) step_col = 1'b1;
      else step_col = (tx * adz) < (tz * adx);
      if (step_col) begin
        tx += cw;
        col += (dx < 0) ? -1 : 1;
      end else begin
        tz += cd;
        row += (dz < 0) ? -1 : 1;
      end
      if (n >= MaxOut || row < mir || row > mr || col < mic || col > mc) begin
        c.last = 1'b1;
        cell_q.push_back(c);
        return;
      end
      cell_q.push_back(c);
    end
  endfunction

  function automatic int draw_gap();
    if (calm || $urandom_range(0, 4) == 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  // ray driver
  always @(posedge clk_i) begin
    bit fire;
    fire = push && !full;
    if (fire) begin
      walk_ray(ray_q.pop_front());
      ray_gap = draw_gap();
    end
    if (!push || fire) begin
      if (ray_gap > 0) begin
        ray_gap--;
        push <= 1'b0;
      end else if (ray_q.size() > 0) begin
        push <= 1'b1;
        ray_origin_x_i <= ray_q[0].org_x;
        ray_origin_z_i <= ray_q[0].org_z;
        ray_dir_x_i <= ray_q[0].dir_x;
        ray_dir_z_i <= ray_q[0].dir_z;
        min_col_i <= ray_q[0].min_c;
        min_row_i <= ray_q[0].min_r;
        max_col_i <= ray_q[0].max_c;
        max_row_i <= ray_q[0].max_r;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // cell monitor
  always @(posedge clk_i) begin
    res_t want;
    if (pop && !empty) begin
      if (cell_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected cell row=%0d col=%0d valid=%0d last=%0d",
                   cell_row_o, cell_col_o, cell_valid_o, last_o);
      end else begin
        want = cell_q.pop_front();
        if (cell_row_o !== want.row || cell_col_o !== want.col ||
            cell_valid_o !== want.valid || last_o !== want.last) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("cell mismatch: exp row=%0d col=%0d valid=%0d last=%0d, got %0d %0d %0d %0d",
                     want.row, want.col, want.valid, want.last,
                     cell_row_o, cell_col_o, cell_valid_o, last_o);
        end
      end
      pop_gap = draw_gap();
    end
    if (!pop || (pop && !empty)) begin
      if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgCellWidth: width_q = data[30:0];
      CfgCellDepth: depth_q = data[30:0];
      CfgOriginX:   gx_q = data;
      CfgOriginZ:   gz_q = data;
      default: ;
    endcase
  endtask

  task automatic add_ray(int ox, int oz, int dx, int dz, int mic, int mir, int mac, int mar);
    ray_t r;
    r.org_x = ox;
    r.org_z = oz;
    r.dir_x = 16'(dx);
    r.dir_z = 16'(dz);
    r.min_c = 5'(mic);
    r.min_r = 5'(mir);
    r.max_c = 5'(mac);
    r.max_r = 5'(mar);
    ray_q.push_back(r);
  endtask

  // random ray, mostly starting inside its window
  task automatic gen_ray();
    longint cw, cd, x, z;
    int col, row, dx, dz, sel;
    ray_t r;
    cw = (width_q == 0) ? 1 : longint'(width_q);
    cd = (depth_q == 0) ? 1 : longint'(depth_q);
    col = $urandom_range(0, 31);
    row = $urandom_range(0, 31);
    x = longint'($signed(gx_q)) + col * cw + $urandom_range(0, 32'(cw - 1));
    z = longint'($signed(gz_q)) + row * cd + $urandom_range(0, 32'(cd - 1));
    sel = $urandom_range(0, 9);
    dx = int'($urandom_range(0, 32768)) - 16384;
    dz = int'($urandom_range(0, 32768)) - 16384;
    if (sel == 1) dx = 0;
    if (sel == 2) dz = 0;
    if (sel == 3) begin
      dx = $urandom();
      dz = $urandom();
    end
    r.org_x = x[31:0];
    r.org_z = z[31:0];
    r.dir_x = 16'(dx);
    r.dir_z = 16'(dz);
    r.min_c = 5'($urandom_range(0, col));
    r.min_r = 5'($urandom_range(0, row));
    r.max_c = 5'($urandom_range(col, 31));
    r.max_r = 5'($urandom_range(row, 31));
    if (sel == 0) begin
      // noise: everything random
      r.org_x = $urandom();
      r.org_z = $urandom();
      r.min_c = 5'($urandom());
      r.min_r = 5'($urandom());
      r.max_c = 5'($urandom());
      r.max_r = 5'($urandom());
    end
    ray_q.push_back(r);
  endtask

  task automatic drain();
    while (ray_q.size() > 0 || push || cell_q.size() > 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] cfg_set [5][4];
    cfg_set = '{
      '{32'd98304, 32'd40000, 32'hFFF0_0000, 32'h0005_0000},
      '{32'h8000_0001, 32'h8000_0000, 32'h0, 32'h0},
      '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF},
      '{32'd4096, 32'd200000, 32'h1234_5678, -32'sd5000},
      '{32'd65536, 32'd65536, 32'h0, 32'h0}
    };
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed rays on the reset grid: unit cells at origin
    add_ray(32'h8000, 32'h8000, 16384, 0, 0, 0, 31, 31);
    add_ray(32'h8000, 32'h8000, 0, 16384, 0, 0, 31, 31);
    add_ray(32'h3_8000, 32'h5_8000, 0, 0, 0, 0, 31, 31);
    add_ray(32'h1F_8000, 32'h1F_8000, -16384, -16384, 0, 0, 31, 31);
    add_ray(32'h10_8000, 32'h10_8000, -32768, 32767, 0, 0, 31, 31);
    add_ray(32'h10_8000, 32'h10_8000, 32767, -32768, 0, 0, 31, 31);
    add_ray(32'h28_0000, 32'h5_0000, 16384, 16384, 0, 0, 31, 31);
    add_ray(32'h5_0000, 32'h5_0000, 16384, 16384, 9, 9, 3, 3);
    add_ray(-32'sh8000, -32'sh8000, 16384, 16384, 0, 0, 31, 31);
    add_ray(-32'sh8000, 32'h8000, -16384, 16384, 0, 0, 31, 31);
    add_ray(32'h8000_0000, 32'h7FFF_FFFF, 1, -1, 0, 0, 31, 31);
    add_ray(32'h7_8000, 32'h7_8000, 16384, 16384, 7, 7, 7, 7);
    add_ray(32'h8000, 32'h8000, 16384, 16383, 0, 0, 31, 31);
    add_ray(32'h0, 32'h0, 16384, 16384, 0, 0, 31, 31);
    add_ray(32'h8000, 32'h8000, 16384, 8192, 0, 0, 31, 31);
    add_ray(32'h1F_FFFF, 32'h0, -5, 16384, 0, 0, 31, 31);
    add_ray(32'h4_0000, 32'h1F_0000, 1000, -16384, 2, 1, 30, 31);
    add_ray(32'hF_0000, 32'hF_0000, 16384, -16384, 31, 31, 31, 31);
    add_ray(32'h2_0000, 32'h2_0000, -16384, 0, 0, 0, 31, 31);
    add_ray(32'h2_0000, 32'h2_0000, 0, -16384, 0, 0, 31, 31);
    drain();

    // random phases, each under its own register setting
    for (int p = 0; p < 5; p++) begin
      calm = (p == 1);
      write_reg(CfgCellWidth, cfg_set[p][0]);
      write_reg(CfgCellDepth, cfg_set[p][1]);
      write_reg(CfgOriginX, cfg_set[p][2]);
      write_reg(CfgOriginZ, cfg_set[p][3]);
      if (p == 4) write_reg(3'd5, 32'hFFFF_FFFF);
      repeat (56) gen_ray();
      drain();
    end

    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
